// ===== hw/rtl/rpbr_pkg.sv =====
// ----------------------------------------------------------------------------
// rpbr_pkg
// shared types, sizes and codes of the reverse post-order renumber unit
// ----------------------------------------------------------------------------
package rpbr_pkg;

  // graph store size and index widths
  localparam int MAX_BLOCKS = 64;
  localparam int IDX_W      = 6;
  localparam int CNT_W      = IDX_W + 1;

  // configuration register index, taken from paddr[2]
  localparam logic REG_ENTRY_BLOCK = 1'b0;

  typedef logic [IDX_W-1:0] blk_idx_t;
  typedef logic [CNT_W-1:0] blk_cnt_t;

  typedef struct packed {
    logic [1:0] count;
    blk_idx_t   succ0;
    blk_idx_t   succ1;
  } edge_entry_t;

  typedef struct packed {
    blk_idx_t   blk;
    logic [1:0] k;
  } stack_entry_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_START,
    S_FETCH,
    S_STEP,
    S_RESTORE,
    S_SCAN,
    S_EMIT_ORD,
    S_EMIT_EDGE,
    S_EMIT_REN,
    S_EMIT_OUT
  } rpbr_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic start;
    logic step;
    logic restore;
    logic scan;
    logic emit_sel;
    logic out_load;
  } rpbr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic entry_ok;
    logic walk_push;
    logic walk_pop;
    logic depth_one;
    logic idx_last;
    logic out_free;
  } rpbr_status_t;

endpackage

// ===== hw/rtl/rpbr_if.sv =====
// ----------------------------------------------------------------------------
// rpbr_if
// valid/ready channels for block words in and renumbered block words out
// ----------------------------------------------------------------------------
interface rpbr_in_if;
  import rpbr_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] successor_count;
  blk_idx_t   first_successor;
  blk_idx_t   second_successor;
  logic       final_block;

  modport source (
    output valid, successor_count, first_successor, second_successor, final_block,
    input  ready
  );
  modport sink (
    input  valid, successor_count, first_successor, second_successor, final_block,
    output ready
  );
endinterface

interface rpbr_out_if;
  import rpbr_pkg::*;

  logic       valid;
  logic       ready;
  blk_idx_t   original_index;
  logic [1:0] out_successor_count;
  blk_idx_t   new_first_successor;
  blk_idx_t   new_second_successor;
  logic       bad_edge;
  logic       last_result;

  modport source (
    output valid, original_index, out_successor_count, new_first_successor,
           new_second_successor, bad_edge, last_result,
    input  ready
  );
  modport sink (
    input  valid, original_index, out_successor_count, new_first_successor,
           new_second_successor, bad_edge, last_result,
    output ready
  );
endinterface

// ===== hw/rtl/rpbr_ctrl.sv =====
// ----------------------------------------------------------------------------
// rpbr_ctrl
// sequencer for load, depth-first walk, unreached scan and emit phases
// ----------------------------------------------------------------------------
module rpbr_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_final_i,
  output logic                  in_ready_o,
  input  rpbr_pkg::rpbr_status_t status_i,
  output rpbr_pkg::rpbr_cmd_t    cmd_o
);
  import rpbr_pkg::*;

  rpbr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_final_i) state_d = S_START;
        end
      end
      S_START: begin
        cmd_o.start = 1'b1;
        state_d     = status_i.entry_ok ? S_FETCH : S_SCAN;
      end
      S_FETCH: begin
        state_d = S_STEP;
      end
      S_STEP: begin
        cmd_o.step = 1'b1;
        if (status_i.walk_push) begin
          state_d = S_FETCH;
        end else if (status_i.walk_pop) begin
          state_d = status_i.depth_one ? S_SCAN : S_RESTORE;
        end
      end
      S_RESTORE: begin
        cmd_o.restore = 1'b1;
        state_d       = S_FETCH;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.idx_last) state_d = S_EMIT_ORD;
      end
      S_EMIT_ORD: begin
        cmd_o.emit_sel = 1'b1;
        state_d        = S_EMIT_EDGE;
      end
      S_EMIT_EDGE: begin
        cmd_o.emit_sel = 1'b1;
        state_d        = S_EMIT_REN;
      end
      S_EMIT_REN: begin
        cmd_o.emit_sel = 1'b1;
        state_d        = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        cmd_o.emit_sel = 1'b1;
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = status_i.idx_last ? S_LOAD : S_EMIT_ORD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

endmodule

// ===== hw/rtl/rpbr_dp.sv =====
// ----------------------------------------------------------------------------
// rpbr_dp
// graph store, walk stack, order and renumber memories, visited map, result
// ----------------------------------------------------------------------------
module rpbr_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rpbr_pkg::rpbr_cmd_t    cmd_i,
  output rpbr_pkg::rpbr_status_t status_o,
  input  rpbr_pkg::blk_idx_t     entry_block_i,
  input  logic [1:0]             successor_count_i,
  input  rpbr_pkg::blk_idx_t     first_successor_i,
  input  rpbr_pkg::blk_idx_t     second_successor_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output rpbr_pkg::blk_idx_t     original_index_o,
  output logic [1:0]             out_successor_count_o,
  output rpbr_pkg::blk_idx_t     new_first_successor_o,
  output rpbr_pkg::blk_idx_t     new_second_successor_o,
  output logic                   bad_edge_o,
  output logic                   last_result_o
);
  import rpbr_pkg::*;

  // memories
  edge_entry_t  edge_mem  [MAX_BLOCKS];
  stack_entry_t stack_mem [MAX_BLOCKS];
  blk_idx_t     order_mem [MAX_BLOCKS];
  blk_idx_t     renum_mem [MAX_BLOCKS];

  edge_entry_t  edge_rd_q;
  stack_entry_t stack_rd_q;
  blk_idx_t     order_rd_q;
  blk_idx_t     ren0_rd_q, ren1_rd_q;

  // control state
  blk_cnt_t              block_total_q;
  logic [MAX_BLOCKS-1:0] visited_q;
  blk_idx_t              top_b_q;
  logic [1:0]            top_k_q;
  blk_cnt_t              depth_q;
  blk_cnt_t              plen_q;
  blk_cnt_t              olen_q;
  blk_cnt_t              idx_q;
  logic                  out_valid_q;

  // result payload
  blk_idx_t   orig_q, nf_q, ns_q;
  logic [1:0] kept_q;
  logic       bad_q, last_q;

  // walk decision
  logic        has_edge, nx_ok, walk_push, walk_pop, entry_ok, idx_last, out_free;
  logic        bt_room;
  blk_idx_t    nx, idx_lo;
  edge_entry_t load_entry;
  logic [1:0]  load_cnt;
  logic [MAX_BLOCKS-1:0] entry_mask;

  assign bt_room  = block_total_q < blk_cnt_t'(MAX_BLOCKS);
  assign has_edge = top_k_q < edge_rd_q.count;
  assign nx       = top_k_q[0] ? edge_rd_q.succ1 : edge_rd_q.succ0;
  assign nx_ok    = ({1'b0, nx} < block_total_q) && !visited_q[nx]
                    && (depth_q < blk_cnt_t'(MAX_BLOCKS));
  assign walk_push = has_edge && nx_ok;
  assign walk_pop  = !has_edge;
  assign entry_ok  = {1'b0, entry_block_i} < block_total_q;
  assign idx_last  = idx_q == (block_total_q - blk_cnt_t'(1));
  assign out_free  = !out_valid_q || out_ready_i;
  assign idx_lo    = idx_q[IDX_W-1:0];
  // visited map at walk start: only the entry block, if it is in the graph
  assign entry_mask = entry_ok ? (MAX_BLOCKS'(1) << entry_block_i) : '0;

  assign status_o.entry_ok  = entry_ok;
  assign status_o.walk_push = walk_push;
  assign status_o.walk_pop  = walk_pop;
  assign status_o.depth_one = depth_q == blk_cnt_t'(1);
  assign status_o.idx_last  = idx_last;
  assign status_o.out_free  = out_free;

  // count of three folds to two
  assign load_cnt         = (successor_count_i == 2'd3) ? 2'd2 : successor_count_i;
  assign load_entry.count = load_cnt;
  assign load_entry.succ0 = first_successor_i;
  assign load_entry.succ1 = second_successor_i;

  // memory addressing
  logic     edge_we, stack_we, order_we, renum_we;
  blk_idx_t edge_raddr, stack_raddr, stack_waddr, order_raddr, order_waddr, order_wdata;
  blk_idx_t renum_waddr, renum_wdata;

  assign edge_we     = cmd_i.load && bt_room;
  assign edge_raddr  = cmd_i.emit_sel ? order_rd_q : top_b_q;
  assign stack_we    = cmd_i.step && walk_push;
  assign stack_waddr = blk_idx_t'(depth_q - blk_cnt_t'(1));
  assign stack_raddr = blk_idx_t'(depth_q - blk_cnt_t'(2));
  // reached blocks sit in post-order at the bottom, read back reversed
  assign order_raddr = (idx_q < plen_q) ? blk_idx_t'(plen_q - blk_cnt_t'(1) - idx_q)
                                        : idx_lo;

  always_comb begin
    order_we    = 1'b0;
    order_waddr = plen_q[IDX_W-1:0];
    order_wdata = top_b_q;
    renum_we    = 1'b0;
    renum_waddr = top_b_q;
    renum_wdata = plen_q[IDX_W-1:0];
    if (cmd_i.step && walk_pop) begin
      order_we = 1'b1;
      renum_we = 1'b1;
    end else if (cmd_i.scan && !visited_q[idx_lo]) begin
      order_we    = 1'b1;
      order_waddr = olen_q[IDX_W-1:0];
      order_wdata = idx_lo;
      renum_we    = 1'b1;
      renum_waddr = idx_lo;
      renum_wdata = olen_q[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (edge_we) edge_mem[block_total_q[IDX_W-1:0]] <= load_entry;
    edge_rd_q <= edge_mem[edge_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (stack_we) stack_mem[stack_waddr] <= '{blk: top_b_q, k: top_k_q + 2'd1};
    stack_rd_q <= stack_mem[stack_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (order_we) order_mem[order_waddr] <= order_wdata;
    order_rd_q <= order_mem[order_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (renum_we) renum_mem[renum_waddr] <= renum_wdata;
    ren0_rd_q <= renum_mem[edge_rd_q.succ0];
    ren1_rd_q <= renum_mem[edge_rd_q.succ1];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_total_q <= '0;
      visited_q     <= '0;
      top_b_q       <= '0;
      top_k_q       <= '0;
      depth_q       <= '0;
      plen_q        <= '0;
      olen_q        <= '0;
      idx_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (edge_we) block_total_q <= block_total_q + blk_cnt_t'(1);
      if (cmd_i.out_load && idx_last) block_total_q <= '0;

      if (cmd_i.start) begin
        visited_q <= entry_mask;
        top_b_q   <= entry_block_i;
        top_k_q   <= 2'd0;
        depth_q   <= entry_ok ? blk_cnt_t'(1) : blk_cnt_t'(0);
        plen_q    <= '0;
        olen_q    <= '0;
        idx_q     <= '0;
      end

      if (cmd_i.step) begin
        if (walk_push) begin
          visited_q[nx] <= 1'b1;
          top_b_q       <= nx;
          top_k_q       <= 2'd0;
          depth_q       <= depth_q + blk_cnt_t'(1);
        end else if (has_edge) begin
          top_k_q <= top_k_q + 2'd1;
        end else begin
          plen_q  <= plen_q + blk_cnt_t'(1);
          olen_q  <= olen_q + blk_cnt_t'(1);
          depth_q <= depth_q - blk_cnt_t'(1);
        end
      end

      if (cmd_i.restore) begin
        top_b_q <= stack_rd_q.blk;
        top_k_q <= stack_rd_q.k;
      end

      if (cmd_i.scan) begin
        if (!visited_q[idx_lo]) olen_q <= olen_q + blk_cnt_t'(1);
        idx_q <= idx_last ? blk_cnt_t'(0) : idx_q + blk_cnt_t'(1);
      end

      if (cmd_i.out_load) idx_q <= idx_q + blk_cnt_t'(1);

      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result assembly: drop out-of-range edges, keep order of the rest
  logic       use0, use1, in0, in1, keep0, keep1;
  blk_idx_t   r0, r1;

  assign use0  = edge_rd_q.count != 2'd0;
  assign use1  = edge_rd_q.count == 2'd2;
  assign in0   = {1'b0, edge_rd_q.succ0} < block_total_q;
  assign in1   = {1'b0, edge_rd_q.succ1} < block_total_q;
  assign keep0 = use0 && in0;
  assign keep1 = use1 && in1;
  // reached blocks hold their post-order slot, flip it to the reversed one
  assign r0 = visited_q[edge_rd_q.succ0]
              ? blk_idx_t'(plen_q - blk_cnt_t'(1) - {1'b0, ren0_rd_q}) : ren0_rd_q;
  assign r1 = visited_q[edge_rd_q.succ1]
              ? blk_idx_t'(plen_q - blk_cnt_t'(1) - {1'b0, ren1_rd_q}) : ren1_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      orig_q <= order_rd_q;
      kept_q <= {1'b0, keep0} + {1'b0, keep1};
      nf_q   <= keep0 ? r0 : (keep1 ? r1 : '0);
      ns_q   <= (keep0 && keep1) ? r1 : '0;
      bad_q  <= (use0 && !in0) || (use1 && !in1);
      last_q <= idx_last;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign original_index_o       = orig_q;
  assign out_successor_count_o  = kept_q;
  assign new_first_successor_o  = nf_q;
  assign new_second_successor_o = ns_q;
  assign bad_edge_o             = bad_q;
  assign last_result_o          = last_q;

  // checks
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= blk_cnt_t'(MAX_BLOCKS))
    else $error("walk stack depth beyond store size");

  a_push_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step && walk_push |=> visited_q[top_b_q] && top_k_q == 2'd0)
    else $error("pushed block not marked visited or edge cursor not cleared");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> out_free)
    else $error("result register overwritten while full");

  a_graph_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load && idx_last |=> block_total_q == '0 && out_valid_q)
    else $error("graph store not emptied after last result");

endmodule

// ===== hw/rtl/reverse_postorder_block_renumber_unit.sv =====
// ----------------------------------------------------------------------------
// reverse_postorder_block_renumber_unit
// renumbers a control-flow graph of up to 64 blocks in reverse post-order
//
// Blocks arrive one word each and are numbered in arrival order. The word
// marked final_block starts a depth-first walk from entry_block, then the
// results stream out, one word per block in new order, with the old index
// and renumbered successors; blocks the walk never reached follow in
// ascending old index, and edges to blocks that were never loaded are dropped
// and flagged in bad_edge. After the final word the unit is busy with walk,
// scan and emit: the walk spends a fetch on entering a block and another
// after each return to it, one step per edge, a pop per reached block and a
// stack restore per return (each fetch a registered memory read), the
// unreached scan visits every loaded block in ascending order, and each
// result passes through the order, edge and renumber memories in turn. No
// block word is taken during walk and emit; the last result may still wait
// in its output register while the next graph loads. entry_block sits at
// byte address 0 of the configuration port and should be written only while
// the unit is idle.
// ----------------------------------------------------------------------------
module reverse_postorder_block_renumber_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  rpbr_in_if.sink     in_i,
  rpbr_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rpbr_pkg::*;

  // configuration register
  blk_idx_t entry_block_q;
  logic     cfg_wr;

  // writes land in the access phase, no wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ENTRY_BLOCK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_block_q <= '0;
    end else if (cfg_wr) begin
      entry_block_q <= pwdata[IDX_W-1:0];
    end
  end

  // addresses past the register list read as zero
  assign prdata = (paddr[2] == REG_ENTRY_BLOCK) ? {{(32-IDX_W){1'b0}}, entry_block_q}
                                                : 32'd0;

  // controller and datapath
  rpbr_cmd_t    cmd;
  rpbr_status_t status;

  rpbr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_final_i (in_i.final_block),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rpbr_dp u_dp (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cmd_i                  (cmd),
    .status_o               (status),
    .entry_block_i          (entry_block_q),
    .successor_count_i      (in_i.successor_count),
    .first_successor_i      (in_i.first_successor),
    .second_successor_i     (in_i.second_successor),
    .out_valid_o            (out_o.valid),
    .out_ready_i            (out_o.ready),
    .original_index_o       (out_o.original_index),
    .out_successor_count_o  (out_o.out_successor_count),
    .new_first_successor_o  (out_o.new_first_successor),
    .new_second_successor_o (out_o.new_second_successor),
    .bad_edge_o             (out_o.bad_edge),
    .last_result_o          (out_o.last_result)
  );

endmodule
